// ===== design/rsmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmq_pkg
// Shared types and constants for the ribbon static map query engine.
// ----------------------------------------------------------------------------
package rsmq_pkg;

	localparam int unsigned BLOCK_BYTES    = 4;
	localparam int unsigned OVERPROVISION  = 1024;
	localparam int unsigned MAX_VALUE_BITS = 64;
	localparam int unsigned STORE_AW       = 14;
	localparam int unsigned REM_W          = 42;

	localparam logic [31:0] STRIDE_FLOOR = 32'((64'd1 << 33) / OVERPROVISION);
	localparam logic [9:0]  NUM_SCALE    = 10'((12 << 8) / BLOCK_BYTES);

	typedef enum logic [1:0] {
		CFG_KEY_BITS    = 2'd0,
		CFG_BLOCK_COUNT = 2'd1
	} cfg_index_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_DEN,
		S_DIV,
		S_PICK,
		S_FIX,
		S_SCAN,
		S_DRAIN,
		S_FIN,
		S_OUT
	} state_t;

	typedef struct packed {
		logic        operation;
		logic [13:0] word_address;
		logic [31:0] word_data;
		logic [63:0] hash_high;
		logic [63:0] hash_low;
	} in_word_t;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  first_block;
		logic [7:0]  second_block;
	} out_word_t;

endpackage

// ===== design/rsmq_store.sv =====
// ----------------------------------------------------------------------------
// rsmq_store
// Map word store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rsmq_store (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [rsmq_pkg::STORE_AW-1:0] wr_addr,
	input  logic [31:0]                   wr_data,
	input  logic                          rd_en,
	input  logic [rsmq_pkg::STORE_AW-1:0] rd_addr_a,
	input  logic [rsmq_pkg::STORE_AW-1:0] rd_addr_b,
	output logic [31:0]                   rd_data_a,
	output logic [31:0]                   rd_data_b
);

	logic [31:0] mem_q [2**rsmq_pkg::STORE_AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== design/rsmq_div.sv =====
// ----------------------------------------------------------------------------
// rsmq_div
// Restoring divider for a 64-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rsmq_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                num,
	input  logic [rsmq_pkg::REM_W-1:0] den,
	output logic                       done,
	output logic [63:0]                quo
);

	logic                       busy_q;
	logic                       done_q;
	logic [5:0]                 cnt_q;
	logic [rsmq_pkg::REM_W-1:0] rem_q;
	logic [rsmq_pkg::REM_W-1:0] den_q;
	logic [63:0]                quo_q;
	logic [rsmq_pkg::REM_W:0]   trial;
	logic                       ge;

	assign trial = {rem_q, quo_q[63]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? rsmq_pkg::REM_W'(trial - {1'b0, den_q}) : trial[rsmq_pkg::REM_W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== design/ribbon_static_map_query.sv =====
// ----------------------------------------------------------------------------
// ribbon_static_map_query
// Query engine for a two-block ribbon static map with a loaded word store.
// ----------------------------------------------------------------------------
// Write word: written to the store when taken, no result.
// Query word: the result waits on the bit-serial divider and then on one paired
// store read per key bit.
// One word at a time; ready only while idle.
// Reset: control and config registers cleared to 8 bits per key, block_count 2;
// the store is not cleared.
module ribbon_static_map_query (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rsmq_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rsmq_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [8:0]          cfg_data
);

	rsmq_pkg::state_t state_q, state_d;

	logic [6:0]  key_bits_q;
	logic [8:0]  block_count_q;

	logic [63:0] hh_q, hl_q;
	logic [8:0]  n_q;
	logic [6:0]  vb_q;
	logic [63:0] sq_q, num_q;
	logic [31:0] m0_q, m1_q;
	logic [8:0]  a_q, b_q;
	logic [13:0] base_a_q, base_b_q;
	logic [5:0]  idx_q, rd_idx_q;
	logic        rd_vld_q;
	logic [63:0] ret_q;
	rsmq_pkg::out_word_t res_q;

	logic        wr_en, rd_en, div_start, div_done;
	logic [63:0] div_quo;
	logic [31:0] rd_a, rd_b;
	logic [41:0] den_raw, den;
	logic [40:0] den_hi, den_lo;
	logic [40:0] a_prod, b_prod;
	logic [15:0] base_a, base_b;
	logic [3:0]  k;
	logic [63:0] smooth;
	logic [31:0] stride;
	logic [63:0] mix_hh, ks0;
	logic [31:0] bseed;
	logic [9:0]  b_inc;
	logic [8:0]  b_fix;
	logic [63:0] vmask;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_bits_q    <= 7'd8;
			block_count_q <= 9'd2;
		end else if (cfg_valid) begin
			case (rsmq_pkg::cfg_index_t'(cfg_index))
				rsmq_pkg::CFG_KEY_BITS:    key_bits_q    <= cfg_data[6:0];
				rsmq_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		k = '0;
		for (int j = 1; j < 9; j++) begin
			if (n_q[j]) k = 4'(j);
		end
	end

	assign smooth = ({60'd0, k} << 48) + ({55'd0, n_q} << (6'd48 - {2'd0, k})) - (64'd1 << 48);
	assign stride = hh_q[31:0] | rsmq_pkg::STRIDE_FLOOR;
	assign mix_hh = hh_q + hl_q;
	assign ks0    = hl_q ^ {mix_hh[24:0], mix_hh[63:25]};

	assign den_hi  = {9'd0, sq_q[63:32]} * {32'd0, n_q};
	assign den_lo  = {9'd0, sq_q[31:0]} * {32'd0, n_q};
	assign den_raw = {1'b0, den_hi} + {33'd0, den_lo[40:32]};
	assign den     = (den_raw == '0) ? 42'd1 : den_raw;

	assign a_prod = {9'd0, hh_q[63:32]} * {32'd0, n_q};
	assign bseed  = div_quo[31:0] + hh_q[63:32];
	assign b_prod = {9'd0, bseed} * {32'd0, n_q};
	assign b_inc  = {1'b0, b_q} + 10'd1;
	assign b_fix  = (b_q != a_q) ? b_q : ((b_inc >= {1'b0, n_q}) ? 9'd0 : b_inc[8:0]);
	assign base_a = {9'd0, vb_q} * {7'd0, a_q};
	assign base_b = {9'd0, vb_q} * {7'd0, b_fix};

	assign vmask = (vb_q >= 7'd64) ? '1 : ((64'd1 << vb_q[5:0]) - 64'd1);

	assign in_ready  = (state_q == rsmq_pkg::S_IDLE);
	assign out_valid = (state_q == rsmq_pkg::S_OUT);
	assign out_data  = res_q;
	assign wr_en     = in_valid && in_ready && (in_data.operation == rsmq_pkg::OP_WRITE);
	assign rd_en     = (state_q == rsmq_pkg::S_SCAN);

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		case (state_q)
			rsmq_pkg::S_IDLE: begin
				if (in_valid && in_data.operation == rsmq_pkg::OP_QUERY) state_d = rsmq_pkg::S_PREP;
			end
			rsmq_pkg::S_PREP: state_d = rsmq_pkg::S_DEN;
			rsmq_pkg::S_DEN: begin
				div_start = 1'b1;
				state_d   = rsmq_pkg::S_DIV;
			end
			rsmq_pkg::S_DIV: begin
				if (div_done) state_d = rsmq_pkg::S_PICK;
			end
			rsmq_pkg::S_PICK: state_d = rsmq_pkg::S_FIX;
			rsmq_pkg::S_FIX: state_d = (vb_q == '0) ? rsmq_pkg::S_DRAIN : rsmq_pkg::S_SCAN;
			rsmq_pkg::S_SCAN: begin
				if ({1'b0, idx_q} == vb_q - 7'd1) state_d = rsmq_pkg::S_DRAIN;
			end
			rsmq_pkg::S_DRAIN: state_d = rsmq_pkg::S_FIN;
			rsmq_pkg::S_FIN: state_d = rsmq_pkg::S_OUT;
			rsmq_pkg::S_OUT: begin
				if (out_ready) state_d = rsmq_pkg::S_IDLE;
			end
			default: state_d = rsmq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rsmq_pkg::S_IDLE;
			rd_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_vld_q <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= idx_q;
		if (rd_vld_q) begin
			ret_q[rd_idx_q] <= ret_q[rd_idx_q] ^ (^((rd_a & m0_q) ^ (rd_b & m1_q)));
		end
		case (state_q)
			rsmq_pkg::S_IDLE: begin
				hh_q <= in_data.hash_high;
				hl_q <= in_data.hash_low;
				n_q  <= block_count_q;
				vb_q <= (key_bits_q > 7'(rsmq_pkg::MAX_VALUE_BITS)) ?
					7'(rsmq_pkg::MAX_VALUE_BITS) : key_bits_q;
			end
			rsmq_pkg::S_PREP: begin
				sq_q  <= {32'd0, stride} * {32'd0, stride};
				num_q <= 64'(smooth * rsmq_pkg::NUM_SCALE);
				a_q   <= a_prod[40:32];
				m0_q  <= ks0[31:0];
				m1_q  <= ks0[63:32];
			end
			rsmq_pkg::S_PICK: b_q <= b_prod[40:32];
			rsmq_pkg::S_FIX: begin
				b_q      <= b_fix;
				base_a_q <= base_a[13:0];
				base_b_q <= base_b[13:0];
				idx_q    <= '0;
				ret_q    <= hl_q;
			end
			rsmq_pkg::S_SCAN: idx_q <= idx_q + 6'd1;
			rsmq_pkg::S_FIN: begin
				res_q.value        <= ret_q & vmask;
				res_q.first_block  <= a_q[7:0];
				res_q.second_block <= b_q[7:0];
			end
			default: ;
		endcase
	end

	rsmq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den),
		.done   (div_done),
		.quo    (div_quo)
	);

	rsmq_store u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (in_data.word_address),
		.wr_data   (in_data.word_data),
		.rd_en     (rd_en),
		.rd_addr_a (base_a_q + {8'd0, idx_q}),
		.rd_addr_b (base_b_q + {8'd0, idx_q}),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
	a_blocks_differ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && n_q >= 9'd2) |-> (a_q != b_q)) else $error("block positions collide");
	a_first_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && n_q != 9'd0) |-> (a_q < n_q)) else $error("first block out of range");
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == rsmq_pkg::S_DIV)) else $error("stray divider done");

endmodule

// ===== dv/tb_ribbon_static_map_query.sv =====
// ----------------------------------------------------------------------------
// tb_ribbon_static_map_query
// Self-checking bench for the ribbon static map query engine. Map words are
// loaded ahead of every query so that only written entries are read; a
// scoreboard predicts block positions and values from its own copy of the
// store and the registers, and checks every result word in order.
// ----------------------------------------------------------------------------
module tb_ribbon_static_map_query;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          DEPTH       = 16384;
	localparam int          STALL_LIMIT = 20000;
	localparam int          SETTLE      = 200;
	localparam logic [1:0]  CFG_SPARE_A = 2'd2;
	localparam logic [1:0]  CFG_SPARE_B = 2'd3;

	class map_query_scoreboard;
		logic [31:0] store [DEPTH];
		logic [6:0]  vbits;
		logic [8:0]  blocks;
		rsmq_pkg::out_word_t pending [$];
		int          errors;
		int          queries;
		int          writes;
		int          settings;

		function new();
			vbits  = 7'd8;
			blocks = 9'd2;
		endfunction

		function void set_reg(logic [1:0] idx, logic [8:0] d);
			settings++;
			if (idx == rsmq_pkg::CFG_KEY_BITS) begin
				vbits = d[6:0];
			end else if (idx == rsmq_pkg::CFG_BLOCK_COUNT) begin
				blocks = d;
			end
		endfunction

		function int eff_bits();
			return (vbits > rsmq_pkg::MAX_VALUE_BITS) ?
				int'(rsmq_pkg::MAX_VALUE_BITS) : int'(vbits);
		endfunction

		function void pick(logic [63:0] hh, output logic [63:0] a, output logic [63:0] b);
			logic [63:0] n, stride, aseed, slog, num, sq, den, bseed;
			int k;
			n      = 64'(blocks);
			stride = {32'd0, hh[31:0]} | 64'(rsmq_pkg::STRIDE_FLOOR);
			aseed  = hh >> 32;
			k      = 0;
			while (k < 63 && (n >> (k + 1)) != 0) k++;
			slog = (64'(k) << 48) + (n << (48 - k)) - (64'd1 << 48);
			num  = slog * 64'(rsmq_pkg::NUM_SCALE);
			sq   = stride * stride;
			den  = (sq >> 32) * n + (((sq & 64'hFFFF_FFFF) * n) >> 32);
			if (den == 0) den = 1;
			bseed = (num / den + aseed) & 64'hFFFF_FFFF;
			a     = (aseed * n) >> 32;
			b     = (bseed * n) >> 32;
			if (a == b) begin
				b++;
				if (b >= n) b = 0;
			end
		endfunction

		function void note(rsmq_pkg::in_word_t w);
			logic [63:0] a, b, ret, mix, ks, addr0, addr1;
			logic [31:0] m0, m1;
			rsmq_pkg::out_word_t r;
			int          vb;
			if (w.operation == rsmq_pkg::OP_WRITE) begin
				store[w.word_address] = w.word_data;
				writes++;
				return;
			end
			queries++;
			pick(w.hash_high, a, b);
			ret = w.hash_low;
			mix = w.hash_high + w.hash_low;
			ks  = w.hash_low ^ {mix[24:0], mix[63:25]};
			m0  = ks[31:0];
			m1  = ks[63:32];
			vb  = eff_bits();
			for (int i = 0; i < vb; i++) begin
				addr0  = 64'(vb) * a + 64'(i);
				addr1  = 64'(vb) * b + 64'(i);
				ret[i] = ret[i] ^ (^((store[addr0[13:0]] & m0) ^ (store[addr1[13:0]] & m1)));
			end
			if (vb < 64) ret &= (64'd1 << vb) - 1;
			r.value        = ret;
			r.first_block  = a[7:0];
			r.second_block = b[7:0];
			pending.push_back(r);
		endfunction

		function void check(rsmq_pkg::out_word_t got);
			rsmq_pkg::out_word_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.value !== exp.value) begin
				$display("%0t: value exp %h got %h", $time, exp.value, got.value);
				errors++;
			end
			if (got.first_block !== exp.first_block) begin
				$display("%0t: first_block exp %h got %h", $time, exp.first_block,
					got.first_block);
				errors++;
			end
			if (got.second_block !== exp.second_block) begin
				$display("%0t: second_block exp %h got %h", $time, exp.second_block,
					got.second_block);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	rsmq_pkg::in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	rsmq_pkg::out_word_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	map_query_scoreboard sb;
	bit written [DEPTH];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;
	int quiet_cycles;
	int items;

	ribbon_static_map_query dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check(out_data);
		if (in_valid && in_ready) sb.note(in_data);
		if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL ribbon_static_map_query");
			$finish;
		end
	end

	// receiver: random back-pressure, or a long hold when asked
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_ready = 1'b0;
				hold_cycles--;
			end else begin
				out_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(rsmq_pkg::in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = w;
		do @(posedge clk); while (!in_ready);
		items++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_cfg(logic [1:0] idx, logic [8:0] d);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_word(logic [13:0] addr, logic [31:0] d);
		rsmq_pkg::in_word_t w;
		w.operation    = rsmq_pkg::OP_WRITE;
		w.word_address = addr;
		w.word_data    = d;
		w.hash_high    = {$urandom, $urandom};
		w.hash_low     = {$urandom, $urandom};
		written[addr]  = 1'b1;
		send_word(w);
	endtask

	// loads any unwritten word of both blocks, then issues the query
	task automatic query_key(logic [63:0] hh, logic [63:0] hl);
		logic [63:0] a, b, addr;
		rsmq_pkg::in_word_t w;
		int          vb;
		sb.pick(hh, a, b);
		vb = sb.eff_bits();
		for (int i = 0; i < vb; i++) begin
			addr = 64'(vb) * a + 64'(i);
			if (!written[addr[13:0]]) write_word(addr[13:0], $urandom);
			addr = 64'(vb) * b + 64'(i);
			if (!written[addr[13:0]]) write_word(addr[13:0], $urandom);
		end
		w.operation    = rsmq_pkg::OP_QUERY;
		w.word_address = 14'($urandom);
		w.word_data    = $urandom;
		w.hash_high    = hh;
		w.hash_low     = hl;
		send_word(w);
	endtask

	initial begin
		int vb_set [9] = '{1, 4, 64, 8, 2, 16, 127, 12, 3};
		int bc_set [9] = '{2, 256, 5, 37, 511, 0, 3, 200, 128};
		int phase_items;
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_data       = '0;
		cfg_valid     = 1'b0;
		cfg_index     = rsmq_pkg::CFG_KEY_BITS;
		cfg_data      = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_cycles   = 0;
		quiet_cycles  = 0;
		items         = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		set_cfg(rsmq_pkg::CFG_KEY_BITS, 9'd8);
		set_cfg(rsmq_pkg::CFG_BLOCK_COUNT, 9'd2);
		for (int i = 0; i < 16; i++) write_word(14'(i), (i % 2) ? 32'hFFFF_FFFF : 32'h0);
		write_word(14'h3FFF, 32'hFFFF_FFFF);
		query_key(64'h0, 64'h0);
		query_key('1, '1);
		query_key(64'h0000_0000_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA);
		query_key(64'hFFFF_FFFF_0000_0000, 64'h5555_5555_5555_5555);
		set_cfg(rsmq_pkg::CFG_KEY_BITS, 9'd0);
		query_key({$urandom, $urandom}, '1);
		set_cfg(rsmq_pkg::CFG_KEY_BITS, 9'd127);
		query_key({$urandom, $urandom}, {$urandom, $urandom});
		set_cfg(rsmq_pkg::CFG_BLOCK_COUNT, 9'd0);
		query_key('1, {$urandom, $urandom});
		set_cfg(rsmq_pkg::CFG_KEY_BITS, 9'd1);
		set_cfg(rsmq_pkg::CFG_BLOCK_COUNT, 9'd511);
		query_key('1, '1);
		query_key(64'h0, {$urandom, $urandom});
		set_cfg(rsmq_pkg::CFG_BLOCK_COUNT, 9'd1);
		query_key({$urandom, $urandom}, {$urandom, $urandom});
		set_cfg(CFG_SPARE_A, 9'h1FF);
		set_cfg(CFG_SPARE_B, 9'h0);
		query_key({$urandom, $urandom}, {$urandom, $urandom});

		// random phases
		for (int p = 0; p < 9; p++) begin
			set_cfg(rsmq_pkg::CFG_KEY_BITS, 9'(vb_set[p]));
			set_cfg(rsmq_pkg::CFG_BLOCK_COUNT, 9'(bc_set[p]));
			send_idle_pct = (p < 3) ? 34 : (p < 6) ? 64 : 0;
			recv_idle_pct = (p < 3) ? 64 : (p < 6) ? 34 : 0;
			if (p == 4 || p == 7) hold_cycles = 600;
			phase_items = items;
			while (items - phase_items < 40) begin
				if ($urandom_range(99) < 20) begin
					write_word(14'($urandom), $urandom);
				end else begin
					query_key({$urandom, $urandom}, {$urandom, $urandom});
				end
			end
		end

		drain();
		$display("Covered %0d queries and %0d map writes over %0d register writes,",
			sb.queries, sb.writes, sb.settings);
		$display("with 0 to 127 bits per key and 0 to 511 blocks under mixed back-pressure.");
		if (sb.errors == 0) begin
			$display("PASS ribbon_static_map_query");
		end else begin
			$display("FAIL ribbon_static_map_query");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/rsmq_pkg.sv
design/rsmq_store.sv
design/rsmq_div.sv
design/ribbon_static_map_query.sv
dv/tb_ribbon_static_map_query.sv
